// File: sv/pdf_pkg.sv
`timescale 1ns / 1ps
package pdf_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] now_seconds;
    logic [15:0] age_limit;
  } pdf_in_t;

  typedef struct packed {
    logic        is_duplicate;
    logic        not_tracked;
    logic [15:0] packet_checksum;
  } pdf_out_t;

  // One finished packet handed from the CRC front end to the table engine.
  typedef struct packed {
    logic [15:0] checksum;
    logic [31:0] now_seconds;
    logic [15:0] age_limit;
  } pdf_job_t;

  // Reflected CRC-16, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/packet_duplicate_filter_core.sv
`timescale 1ns / 1ps
// Bytes: one per cycle; the CRC front end stalls only when two finished packets wait.
// Per packet the table engine reads one table entry per cycle from a single-read-port
// memory, then takes a finish step that waits while the result register is stalled.
// Reset (rst_ni, async, active low) restores the CRC to 0xFFFF, empties the
// queue and sets the entry count to zero; table memory is not cleared.
module packet_duplicate_filter_core import pdf_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 20
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pdf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pdf_out_t out_data_o
);

  // Front end -> queue: one job per packet, pushed on the transfer of the last byte.
  logic     job_push;
  pdf_job_t job_in;
  logic     job_full;

  // Queue -> table engine.
  logic     job_valid;
  logic     job_pop;
  pdf_job_t job_out;

  // CRC-16 over the byte stream; finishes the checksum on the last byte.
  pdf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  // Decouples the byte stream from the table search.
  pdf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .full_o      (job_full),
    .pop_i       (job_pop),
    .valid_o     (job_valid),
    .pop_data_o  (job_out)
  );

  // Linear table search: frees stale matches, flags young ones, stores new checksums
  // in the first free slot or appends, else marks untracked; holds the result register.
  pdf_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/pdf_front.sv
`timescale 1ns / 1ps
module pdf_front import pdf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pdf_in_t  in_data_i,
  output logic     job_push_o,
  output pdf_job_t job_o,
  input  logic     job_full_i
);

  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_next;
  logic        accept;

  assign in_stall_o = job_full_i;
  assign accept     = in_valid_i && !job_full_i;
  assign crc_next   = crc16_byte(crc_q, in_data_i.data_byte);

  always_comb begin
    crc_d = crc_q;
    if (accept) begin
      crc_d = in_data_i.last_byte ? CRC_INIT : crc_next;
    end
  end

  assign job_push_o        = accept && in_data_i.last_byte;
  assign job_o.checksum    = ~crc_next;
  assign job_o.now_seconds = in_data_i.now_seconds;
  assign job_o.age_limit   = in_data_i.age_limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

// File: sv/pdf_queue.sv
`timescale 1ns / 1ps
module pdf_queue import pdf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pdf_job_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output pdf_job_t pop_data_o
);

  // two-entry FIFO
  pdf_job_t   slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: sv/pdf_back.sv
`timescale 1ns / 1ps
module pdf_back import pdf_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 20
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  input  pdf_job_t job_i,
  output logic     job_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pdf_out_t out_data_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(TABLE_ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  pdf_job_t         job_q, job_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic             dup_q, dup_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;

  logic [15:0]      mem_chk  [TABLE_ENTRIES];
  logic [31:0]      mem_time [TABLE_ENTRIES];
  logic [15:0]      rd_chk_q;
  logic [31:0]      rd_time_q;
  logic [IDX_W-1:0] chk_idx_q;

  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_chk_en, wr_time_en;
  logic [IDX_W-1:0] wr_addr;
  logic [15:0]      wr_chk;

  logic             out_valid_q, out_valid_d;
  pdf_out_t         out_data_q, out_data_d;
  logic             out_free;

  logic [31:0]      age_diff;
  logic             match, young;

  assign out_free = !out_valid_q || !out_stall_i;
  assign age_diff = job_q.now_seconds - rd_time_q;
  assign match    = (rd_chk_q == job_q.checksum);
  // negative difference always counts as young
  assign young    = age_diff[31] || (age_diff < {16'd0, job_q.age_limit});

  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    issue_d      = issue_q;
    used_d       = used_q;
    dup_d        = dup_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    job_pop_o    = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_chk_en    = 1'b0;
    wr_time_en   = 1'b0;
    wr_addr      = '0;
    wr_chk       = '0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;

    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o    = 1'b1;
          job_d        = job_i;
          dup_d        = 1'b0;
          free_found_d = 1'b0;
          if (used_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            issue_d = CNT_W'(1);
            state_d = S_SCAN;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SCAN: begin
        // one entry checked per cycle, next read already in flight
        if (match && young) begin
          dup_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          if (match) begin
            wr_chk_en = 1'b1;
            wr_addr   = chk_idx_q;
            wr_chk    = '0;
          end
          if ((rd_chk_q == '0 || match) && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = chk_idx_q;
          end
          if (issue_q < used_q) begin
            rd_en   = 1'b1;
            rd_addr = issue_q[IDX_W-1:0];
            issue_d = issue_q + CNT_W'(1);
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_data_d.is_duplicate    = dup_q;
          out_data_d.not_tracked     = 1'b0;
          out_data_d.packet_checksum = job_q.checksum;
          if (!dup_q) begin
            if (free_found_q) begin
              wr_chk_en  = 1'b1;
              wr_time_en = 1'b1;
              wr_addr    = free_idx_q;
              wr_chk     = job_q.checksum;
            end else if (used_q < ENTRIES_C) begin
              wr_chk_en  = 1'b1;
              wr_time_en = 1'b1;
              wr_addr    = used_q[IDX_W-1:0];
              wr_chk     = job_q.checksum;
              used_d     = used_q + CNT_W'(1);
            end else begin
              out_data_d.not_tracked = 1'b1;
            end
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_chk_en) begin
      mem_chk[wr_addr] <= wr_chk;
    end
    if (wr_time_en) begin
      mem_time[wr_addr] <= job_q.now_seconds;
    end
    if (rd_en) begin
      rd_chk_q  <= mem_chk[rd_addr];
      rd_time_q <= mem_time[rd_addr];
      chk_idx_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    issue_q    <= issue_d;
    free_idx_q <= free_idx_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      dup_q        <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      dup_q        <= dup_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: sv/pdf_checker.sv
`timescale 1ns / 1ps
module pdf_checker import pdf_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input pdf_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input pdf_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_dup_untracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.is_duplicate && out_data_o.not_tracked))
    else $error("duplicate also flagged untracked");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && in_data_i.last_byte))
    else $error("input stall without a finished packet");

endmodule

bind packet_duplicate_filter_core pdf_checker u_pdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
